/* rtl/smsenc_pkg.sv */
`default_nettype none

package smsenc_pkg;

  // Counter width default
  localparam int COUNT_BITS_DEF = 16;

  // Status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_BAD_UTF8    = 2'd1;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd2;
  localparam logic [1:0] ST_NO_SPACE    = 2'd3;

  // Mode codes
  localparam logic [1:0] MODE_GSM7 = 2'd0;
  localparam logic [1:0] MODE_UCS2 = 2'd1;
  localparam logic [1:0] MODE_RAW  = 2'd2;
  localparam logic [1:0] MODE_NONE = 2'd3;

  // Register indexes
  localparam int          CFG_IDX_W   = 1;
  localparam logic [0:0]  REG_MODE    = 1'd0;
  localparam logic [0:0]  REG_MAX_OUT = 1'd1;
  localparam logic [15:0] MAX_OUT_RST = 16'd140;

  // Item kinds
  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Constraint on the first continuation byte
  localparam logic [2:0] LC_NONE = 3'd0;
  localparam logic [2:0] LC_E0   = 3'd1;
  localparam logic [2:0] LC_ED   = 3'd2;
  localparam logic [2:0] LC_F0   = 3'd3;
  localparam logic [2:0] LC_F4   = 3'd4;

  localparam logic [6:0]  GSM_ESC   = 7'h1B;
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  // Basic table: position is the septet; slot 27 is the escape and never matches
  localparam logic [20:0] GSM_BASIC [32] = '{
    21'h00040, 21'h000A3, 21'h00024, 21'h000A5, 21'h000E8, 21'h000E9, 21'h000F9, 21'h000EC,
    21'h000F2, 21'h000C7, 21'h0000A, 21'h000D8, 21'h000F8, 21'h0000D, 21'h000C5, 21'h000E5,
    21'h00394, 21'h0005F, 21'h003A6, 21'h00393, 21'h0039B, 21'h003A9, 21'h003A0, 21'h003A8,
    21'h003A3, 21'h00398, 21'h0039E, 21'h1FFFFF, 21'h000C6, 21'h000E6, 21'h000DF, 21'h000C9
  };

  typedef struct packed {
    logic       hit;
    logic       ext;
    logic [6:0] sep;
  } gsm_hit_t;

  typedef struct packed {
    logic [14:0] acc;
    logic [3:0]  held;
    logic        emit;
    logic [7:0]  data;
  } pack_t;

  // Results caused by one item: bytes first, then an optional summary
  typedef struct packed {
    logic [2:0]      nb;
    logic            has_sum;
    logic [1:0]      st;
    logic [15:0]     units;
    logic [3:0][7:0] data;
  } bundle_t;

  // Code point to GSM septet; ext marks an escape-prefixed character
  function automatic gsm_hit_t gsm_map(input logic [20:0] cp);
    gsm_hit_t r;
    r     = '0;
    r.hit = 1'b1;
    r.ext = 1'b1;
    case (cp)
      21'h0000C: r.sep = 7'h0A;
      21'h0005E: r.sep = 7'h14;
      21'h0007B: r.sep = 7'h28;
      21'h0007D: r.sep = 7'h29;
      21'h0005C: r.sep = 7'h2F;
      21'h0005B: r.sep = 7'h3C;
      21'h0007E: r.sep = 7'h3D;
      21'h0005D: r.sep = 7'h3E;
      21'h0007C: r.sep = 7'h40;
      21'h020AC: r.sep = 7'h65;
      default: begin
        r.ext = 1'b0;
        r.hit = 1'b0;
        for (int i = 0; i < 32; i++) begin
          if (GSM_BASIC[i] == cp) begin
            r.hit = 1'b1;
            r.sep = 7'(i);
          end
        end
        // other printable ASCII up to 0x7A maps to itself, backquote excepted
        if (!r.hit && cp >= 21'h20 && cp <= 21'h7A && cp != 21'h60) begin
          r.hit = 1'b1;
          r.sep = cp[6:0];
        end
        if (!r.hit) begin
          r.hit = 1'b1;
          case (cp)
            21'h000A4: r.sep = 7'h24;
            21'h000A1: r.sep = 7'h40;
            21'h000BF: r.sep = 7'h60;
            21'h000C4: r.sep = 7'h5B;
            21'h000D6: r.sep = 7'h5C;
            21'h000D1: r.sep = 7'h5D;
            21'h000DC: r.sep = 7'h5E;
            21'h000A7: r.sep = 7'h5F;
            21'h000E4: r.sep = 7'h7B;
            21'h000F6: r.sep = 7'h7C;
            21'h000F1: r.sep = 7'h7D;
            21'h000FC: r.sep = 7'h7E;
            21'h000E0: r.sep = 7'h7F;
            default:   r.hit = 1'b0;
          endcase
        end
      end
    endcase
    return r;
  endfunction

  // Add one septet LSB first; at most one byte falls out (held stays below 8)
  function automatic pack_t pack_septet(input logic [14:0] acc, input logic [3:0] held,
                                        input logic [6:0] sep);
    pack_t       r;
    logic [14:0] v;
    logic [3:0]  h;
    v      = acc | ({8'b0, sep} << held);
    h      = held + 4'd7;
    r.emit = h[3];
    r.data = v[7:0];
    r.acc  = h[3] ? {8'b0, v[14:8]} : v;
    r.held = h[3] ? (h - 4'd8) : h;
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/sms_user_data_text_encoder_top.sv */
`default_nettype none

// Channel  | handshake                  | payload
// ---------+----------------------------+------------------------------------------
// input    | in_valid / in_stall        | kind, in_byte
// output   | out_valid / out_stall      | out_byte, byte_valid, done_res, status,
//          |                            | unit_count
// config   | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// One input item per cycle while in_stall is low: validation and encoding are one registered pass.
// An item yields up to four results, queued as one bundle in a two-entry queue
// and sent one per cycle unless out_stall is high; the next item may enter while they drain.
// in_stall is high only while the queue is full; an out_stall holds the current result.
// Synchronous reset clears the stream state and the queue; mode 0, capacity 140.
// cfg_ready is always high.
module sms_user_data_text_encoder_top #(
  parameter int COUNT_BITS = smsenc_pkg::COUNT_BITS_DEF
) (
  input  wire                               clk,
  input  wire                               rst,
  // input channel
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire                               kind,
  input  wire  [7:0]                        in_byte,
  // output channel
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic [7:0]                        out_byte,
  output logic                              byte_valid,
  output logic                              done_res,
  output logic [1:0]                        status,
  output logic [15:0]                       unit_count,
  // configuration
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [smsenc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [15:0]                       cfg_data
);

  localparam int CW = COUNT_BITS;

  // Registers
  logic [1:0]  mode;
  logic [15:0] max_out;
  logic [20:0] partial;
  logic [1:0]  pending;
  logic [2:0]  lclass;
  logic [14:0] acc;
  logic [3:0]  held;
  logic [CW-1:0] units_done;
  logic [15:0] emitted;
  logic [1:0]  err;

  logic [20:0] partial_next;
  logic [1:0]  pending_next;
  logic [2:0]  lclass_next;
  logic [14:0] acc_next;
  logic [3:0]  held_next;
  logic [CW-1:0] units_next;
  logic [15:0] emitted_next;
  logic [1:0]  err_next;

  // Result queue
  smsenc_pkg::bundle_t bq [2];
  logic        wp;
  logic        rp;
  logic [1:0]  qcnt;
  logic [1:0]  sub;

  // Handshakes
  logic in_acc;
  logic out_acc;
  logic push;
  logic pop_b;
  logic is_text;
  logic is_end;

  // Validator
  logic        active;
  logic        checking;
  logic        v_fail;
  logic        v_cp_done;
  logic [20:0] v_cp;
  logic [20:0] v_pcp;
  logic [1:0]  v_pend;
  logic [2:0]  v_lc;

  // Encoder
  smsenc_pkg::gsm_hit_t gsm;
  smsenc_pkg::pack_t    p0;
  smsenc_pkg::pack_t    p1;
  logic [19:0]     sv;
  logic [20:0]     sv_full;
  logic [3:0][7:0] c_byte;
  logic [2:0]      c_n;
  logic [2:0]      ne;
  logic [3:0]      fits;
  logic [1:0]      e_st;
  logic [15:0]     units16;
  smsenc_pkg::bundle_t bnd;

  // Output side
  smsenc_pkg::bundle_t head;
  logic [2:0]      total;
  logic            is_sum;
  logic            last;

  function automatic logic [CW-1:0] add_units(input logic [CW-1:0] u, input logic [2:0] n);
    logic [CW:0] s;
    s = {1'b0, u} + (CW+1)'(n);
    return s[CW] ? {CW{1'b1}} : s[CW-1:0];
  endfunction

  assign in_stall  = (qcnt == 2'd2);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && !in_stall;
  assign is_text   = in_acc && (kind == smsenc_pkg::KIND_TEXT);
  assign is_end    = in_acc && (kind == smsenc_pkg::KIND_END);
  assign active    = (err == smsenc_pkg::ST_OK);
  assign checking  = (err == smsenc_pkg::ST_NO_SPACE) && (mode == smsenc_pkg::MODE_RAW);

  // Room check for the next four output bytes
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      fits[k] = (({1'b0, emitted} + 17'(k)) < {1'b0, max_out});
    end
  end

  // Summary count, clipped to 16 bits
  always_comb begin
    if (({16'b0, units_done}) > (CW+16)'(16'hFFFF)) begin
      units16 = 16'hFFFF;
    end else begin
      units16 = 16'(units_done);
    end
  end

  // UTF-8 validator step
  always_comb begin
    v_fail    = 1'b0;
    v_cp_done = 1'b0;
    v_cp      = '0;
    v_pcp     = partial;
    v_pend    = pending;
    v_lc      = lclass;
    if (pending == 2'd0) begin
      if (in_byte != 8'h00 && !in_byte[7]) begin
        v_cp_done = 1'b1;
        v_cp      = {13'b0, in_byte};
      end else begin
        v_lc = smsenc_pkg::LC_NONE;
        if (in_byte >= 8'hC2 && in_byte <= 8'hDF) begin
          v_pend = 2'd1;
          v_pcp  = {16'b0, in_byte[4:0]};
        end else if (in_byte[7:4] == 4'hE) begin
          v_pend = 2'd2;
          v_pcp  = {17'b0, in_byte[3:0]};
          if (in_byte == 8'hE0) begin
            v_lc = smsenc_pkg::LC_E0;
          end else if (in_byte == 8'hED) begin
            v_lc = smsenc_pkg::LC_ED;
          end
        end else if (in_byte >= 8'hF0 && in_byte <= 8'hF4) begin
          v_pend = 2'd3;
          v_pcp  = {18'b0, in_byte[2:0]};
          if (in_byte == 8'hF0) begin
            v_lc = smsenc_pkg::LC_F0;
          end else if (in_byte == 8'hF4) begin
            v_lc = smsenc_pkg::LC_F4;
          end
        end else begin
          v_fail = 1'b1;
        end
      end
    end else begin
      // continuation byte; first one may be range-limited by the lead byte
      if (in_byte[7:6] != 2'b10 ||
          (lclass == smsenc_pkg::LC_E0 && in_byte <  8'hA0) ||
          (lclass == smsenc_pkg::LC_ED && in_byte >= 8'hA0) ||
          (lclass == smsenc_pkg::LC_F0 && in_byte <  8'h90) ||
          (lclass == smsenc_pkg::LC_F4 && in_byte >  8'h8F)) begin
        v_fail = 1'b1;
      end else begin
        v_lc   = smsenc_pkg::LC_NONE;
        v_pcp  = {partial[14:0], in_byte[5:0]};
        v_pend = pending - 2'd1;
        if (v_pend == 2'd0) begin
          v_cp_done = 1'b1;
          v_cp      = v_pcp;
          v_pcp     = '0;
        end
      end
    end
    if (v_fail) begin
      v_pend = 2'd0;
      v_lc   = smsenc_pkg::LC_NONE;
      v_pcp  = '0;
    end
  end

  // GSM7 mapping and septet packing
  assign gsm = smsenc_pkg::gsm_map(v_cp);
  assign p0  = smsenc_pkg::pack_septet(acc, held, gsm.ext ? smsenc_pkg::GSM_ESC : gsm.sep);
  assign p1  = smsenc_pkg::pack_septet(p0.acc, p0.held, gsm.sep);

  // Surrogate offset for UCS2
  assign sv_full = v_cp - smsenc_pkg::SUPP_BASE;
  assign sv      = sv_full[19:0];

  // Candidate bytes per mode
  always_comb begin
    c_byte = '0;
    c_n    = 3'd0;
    case (mode)
      smsenc_pkg::MODE_GSM7: begin
        c_byte[0] = p0.emit ? p0.data : p1.data;
        c_byte[1] = p1.data;
        c_n       = {2'b0, p0.emit} + {2'b0, gsm.ext & p1.emit};
      end
      smsenc_pkg::MODE_UCS2: begin
        if (v_cp[20:16] == 5'd0) begin
          c_byte[0] = v_cp[15:8];
          c_byte[1] = v_cp[7:0];
          c_n       = 3'd2;
        end else begin
          c_byte[0] = {6'b110110, sv[19:18]};
          c_byte[1] = sv[17:10];
          c_byte[2] = {6'b110111, sv[9:8]};
          c_byte[3] = sv[7:0];
          c_n       = 3'd4;
        end
      end
      default: begin
        // raw: re-encode the code point, which gives back the input bytes
        if (v_cp < 21'h80) begin
          c_byte[0] = v_cp[7:0];
          c_n       = 3'd1;
        end else if (v_cp < 21'h800) begin
          c_byte[0] = {3'b110, v_cp[10:6]};
          c_byte[1] = {2'b10, v_cp[5:0]};
          c_n       = 3'd2;
        end else if (v_cp < 21'h10000) begin
          c_byte[0] = {4'b1110, v_cp[15:12]};
          c_byte[1] = {2'b10, v_cp[11:6]};
          c_byte[2] = {2'b10, v_cp[5:0]};
          c_n       = 3'd3;
        end else begin
          c_byte[0] = {5'b11110, v_cp[20:18]};
          c_byte[1] = {2'b10, v_cp[17:12]};
          c_byte[2] = {2'b10, v_cp[11:6]};
          c_byte[3] = {2'b10, v_cp[5:0]};
          c_n       = 3'd4;
        end
      end
    endcase
  end

  // Bytes that fit; UCS2 goes by whole 16-bit units
  always_comb begin
    ne = 3'd0;
    if (mode == smsenc_pkg::MODE_UCS2) begin
      if (c_n == 3'd4 && fits[3]) begin
        ne = 3'd4;
      end else if (fits[1]) begin
        ne = 3'd2;
      end
    end else begin
      for (int k = 0; k < 4; k++) begin
        if (3'(k) < c_n && fits[k]) begin
          ne = 3'(k + 1);
        end
      end
    end
  end

  // Next state and result bundle
  always_comb begin
    partial_next = partial;
    pending_next = pending;
    lclass_next  = lclass;
    acc_next     = acc;
    held_next    = held;
    units_next   = units_done;
    emitted_next = emitted;
    err_next     = err;
    bnd          = '0;
    e_st         = err;
    if (is_text) begin
      if (mode == smsenc_pkg::MODE_NONE) begin
        if (active) begin
          err_next = smsenc_pkg::ST_UNSUPPORTED;
        end
      end else if (active || checking) begin
        partial_next = v_pcp;
        pending_next = v_pend;
        lclass_next  = v_lc;
        if (v_fail) begin
          err_next = smsenc_pkg::ST_BAD_UTF8;
        end else if (v_cp_done && active) begin
          if (mode == smsenc_pkg::MODE_GSM7 && !gsm.hit) begin
            err_next = smsenc_pkg::ST_UNSUPPORTED;
          end else begin
            bnd.nb       = ne;
            bnd.data     = c_byte;
            emitted_next = emitted + {13'b0, ne};
            if (ne != c_n) begin
              err_next = smsenc_pkg::ST_NO_SPACE;
            end
            if (mode == smsenc_pkg::MODE_GSM7) begin
              acc_next   = gsm.ext ? p1.acc : p0.acc;
              held_next  = gsm.ext ? p1.held : p0.held;
              units_next = add_units(units_done, gsm.ext ? 3'd2 : 3'd1);
            end else begin
              units_next = add_units(units_done, ne);
            end
          end
        end
      end
    end else if (is_end) begin
      if (mode == smsenc_pkg::MODE_NONE && e_st == smsenc_pkg::ST_OK) begin
        e_st = smsenc_pkg::ST_UNSUPPORTED;
      end
      // truncated sequence
      if (pending != 2'd0 && (e_st == smsenc_pkg::ST_OK ||
          (e_st == smsenc_pkg::ST_NO_SPACE && mode == smsenc_pkg::MODE_RAW))) begin
        e_st = smsenc_pkg::ST_BAD_UTF8;
      end
      // flush the partial GSM7 byte
      if (e_st == smsenc_pkg::ST_OK && mode == smsenc_pkg::MODE_GSM7 && held != 4'd0) begin
        if (fits[0]) begin
          bnd.nb      = 3'd1;
          bnd.data[0] = acc[7:0];
        end else begin
          e_st = smsenc_pkg::ST_NO_SPACE;
        end
      end
      bnd.has_sum  = 1'b1;
      bnd.st       = e_st;
      bnd.units    = (e_st == smsenc_pkg::ST_OK) ? units16 : 16'd0;
      partial_next = '0;
      pending_next = 2'd0;
      lclass_next  = smsenc_pkg::LC_NONE;
      acc_next     = '0;
      held_next    = 4'd0;
      units_next   = '0;
      emitted_next = 16'd0;
      err_next     = smsenc_pkg::ST_OK;
    end
  end

  assign push = in_acc && (bnd.nb != 3'd0 || bnd.has_sum);

  // Output selection from the head bundle
  assign head       = bq[rp];
  assign total      = head.nb + {2'b0, head.has_sum};
  assign is_sum     = head.has_sum && ({1'b0, sub} == head.nb);
  assign last       = (({1'b0, sub} + 3'd1) == total);
  assign out_valid  = (qcnt != 2'd0);
  assign out_acc    = out_valid && !out_stall;
  assign pop_b      = out_acc && last;
  assign out_byte   = is_sum ? 8'h00 : head.data[sub];
  assign byte_valid = !is_sum;
  assign done_res   = is_sum;
  assign status     = is_sum ? head.st : smsenc_pkg::ST_OK;
  assign unit_count = is_sum ? head.units : 16'd0;

  // Control and stream state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= smsenc_pkg::MODE_GSM7;
      max_out    <= smsenc_pkg::MAX_OUT_RST;
      partial    <= '0;
      pending    <= 2'd0;
      lclass     <= smsenc_pkg::LC_NONE;
      acc        <= '0;
      held       <= 4'd0;
      units_done <= '0;
      emitted    <= 16'd0;
      err        <= smsenc_pkg::ST_OK;
      wp         <= 1'b0;
      rp         <= 1'b0;
      qcnt       <= 2'd0;
      sub        <= 2'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          smsenc_pkg::REG_MODE:    mode    <= cfg_data[1:0];
          smsenc_pkg::REG_MAX_OUT: max_out <= cfg_data;
        endcase
      end
      if (in_acc) begin
        partial    <= partial_next;
        pending    <= pending_next;
        lclass     <= lclass_next;
        acc        <= acc_next;
        held       <= held_next;
        units_done <= units_next;
        emitted    <= emitted_next;
        err        <= err_next;
      end
      if (push) begin
        wp <= ~wp;
      end
      if (out_acc) begin
        if (last) begin
          sub <= 2'd0;
          rp  <= ~rp;
        end else begin
          sub <= sub + 2'd1;
        end
      end
      qcnt <= qcnt + {1'b0, push} - {1'b0, pop_b};
    end
  end

  // Bundle storage
  always_ff @(posedge clk) begin
    if (push) begin
      bq[wp] <= bnd;
    end
  end

  // Checks
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> (qcnt != 2'd2))
    else $error("bundle pushed into full queue");

  a_byte_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && byte_valid) |-> (!done_res && status == smsenc_pkg::ST_OK &&
                                   unit_count == 16'd0))
    else $error("byte result carries summary fields");

  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    (err != smsenc_pkg::ST_OK && !is_end) |=> (err != smsenc_pkg::ST_OK))
    else $error("error cleared before end of message");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    is_end |=> (err == smsenc_pkg::ST_OK && pending == 2'd0 && held == 4'd0))
    else $error("stream state not cleared after end item");

  a_bad_sum_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_res && status != smsenc_pkg::ST_OK) |-> (unit_count == 16'd0))
    else $error("failed summary reports a unit count");

endmodule

`default_nettype wire
